>>> src/tw_rtc_pkg.sv
// ----------------------------------------------------------------------------
// tw_rtc_pkg
// Shared widths, command codes, register indexes and BCD helpers for the
// three-wire real-time-clock bus master.
// ----------------------------------------------------------------------------
package tw_rtc_pkg;

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 8;
  localparam int VALUE_W  = 7;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CE_SETUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CE_SETUP_RESET = 8'd5;
  localparam logic [CFG_DATA_W-1:0] PHASE_RESET    = 8'd1;

  localparam logic [BYTE_W-1:0] MAX_READ_VALUE = 8'd165;

  typedef struct packed {
    logic              ce_pin;
    logic              sclk_pin;
    logic              io_out;
    logic              io_drive;
    logic              busy_res;
    logic              read_valid;
    logic [BYTE_W-1:0] read_value;
  } res_t;

  // tens digit by reciprocal multiply, exact for all 7-bit values
  function automatic logic [BYTE_W-1:0] to_bcd(input logic [VALUE_W-1:0] v);
    logic [18:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    prod = 19'(v) * 19'd205;
    tens = prod[14:11];
    ones = 8'(v) - 8'(tens) * 8'd10;
    return {tens, 4'd0} + ones;
  endfunction

  function automatic logic [BYTE_W-1:0] from_bcd(input logic [BYTE_W-1:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

endpackage

>>> src/tw_rtc_cmd_if.sv
// ----------------------------------------------------------------------------
// tw_rtc_cmd_if
// Tick/command request channel: valid, ready and one bus tick's inputs.
// ----------------------------------------------------------------------------
interface tw_rtc_cmd_if;
  import tw_rtc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ADDR_W-1:0]  reg_addr;
  logic [VALUE_W-1:0] write_value;
  logic               io_in;

  modport source (output valid, func, reg_addr, write_value, io_in, input ready);
  modport sink (input valid, func, reg_addr, write_value, io_in, output ready);
endinterface

>>> src/tw_rtc_res_if.sv
// ----------------------------------------------------------------------------
// tw_rtc_res_if
// Result channel: valid, ready and the pin levels and read data of one tick.
// ----------------------------------------------------------------------------
interface tw_rtc_res_if;
  import tw_rtc_pkg::*;

  logic              valid;
  logic              ready;
  logic              ce_pin;
  logic              sclk_pin;
  logic              io_out;
  logic              io_drive;
  logic              busy_res;
  logic              read_valid;
  logic [BYTE_W-1:0] read_value;

  modport source (output valid, ce_pin, sclk_pin, io_out, io_drive, busy_res,
                  read_valid, read_value, input ready);
  modport sink (input valid, ce_pin, sclk_pin, io_out, io_drive, busy_res,
                read_valid, read_value, output ready);
endinterface

>>> src/tw_rtc_cfg_if.sv
// ----------------------------------------------------------------------------
// tw_rtc_cfg_if
// Configuration write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface tw_rtc_cfg_if;
  import tw_rtc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> src/tw_rtc_core.sv
// ----------------------------------------------------------------------------
// tw_rtc_core
// Bus sequencer: timing registers, access state and the one-tick step logic
// that yields the pin levels and read data for each accepted request.
// ----------------------------------------------------------------------------
module tw_rtc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [tw_rtc_pkg::FUNC_W-1:0]  func,
  input  logic [tw_rtc_pkg::ADDR_W-1:0]  reg_addr,
  input  logic [tw_rtc_pkg::VALUE_W-1:0] write_value,
  input  logic                         io_in,
  tw_rtc_cfg_if.sink                   cfg,
  output tw_rtc_pkg::res_t             result
);
  import tw_rtc_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_TX    = 3'd2;
  localparam logic [2:0] PH_RX    = 3'd3;
  localparam logic [2:0] PH_HOLD  = 3'd4;
  localparam logic [1:0] CP_SAMPLE = 2'd3;

  logic [7:0] ce_setup_ticks;
  logic [7:0] phase_ticks;

  logic [2:0] phase, phase_next;
  logic       is_read, is_read_next;
  logic [3:0] bit_index, bit_index_next;
  logic [1:0] clock_phase, clock_phase_next;
  logic [7:0] wait_count, wait_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] data_byte, data_byte_next;
  logic [7:0] recv_byte, recv_byte_next;

  logic       start;
  logic [2:0] phase_s;
  logic       is_read_s;
  logic [3:0] bit_s;
  logic [1:0] cp_s;
  logic [7:0] wait_s, shift_s, data_s, recv_s;
  logic [7:0] setup_one, phase_one;
  logic       ph_end;
  logic [7:0] tx_byte;
  logic       tx_last;

  assign cfg.ready = 1'b1;
  assign setup_one = (ce_setup_ticks == 8'd0) ? 8'd1 : ce_setup_ticks;
  assign phase_one = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      ce_setup_ticks <= CE_SETUP_RESET;
      phase_ticks    <= PHASE_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_CE_SETUP: ce_setup_ticks <= cfg.data;
        CFG_PHASE:    phase_ticks    <= cfg.data;
        default: ;
      endcase
    end
  end

  // command launch
  always_comb begin
    start     = (phase == PH_IDLE) && (func == FUNC_WRITE || func == FUNC_READ);
    phase_s   = start ? PH_SETUP : phase;
    is_read_s = start ? (func == FUNC_READ) : is_read;
    shift_s   = start ? ((func == FUNC_READ) ? (reg_addr | 8'h01) : reg_addr) : shift_byte;
    data_s    = start ? ((func == FUNC_READ) ? 8'd0 : to_bcd(write_value)) : data_byte;
    recv_s    = start ? 8'd0 : recv_byte;
    bit_s     = start ? 4'd0 : bit_index;
    cp_s      = start ? 2'd0 : clock_phase;
    wait_s    = start ? setup_one : wait_count;
  end

  assign ph_end  = (wait_s <= 8'd1);
  assign tx_byte = bit_s[3] ? data_s : shift_s;
  assign tx_last = is_read_s ? (bit_s >= 4'd7) : (bit_s == 4'd15);

  always_comb begin
    phase_next       = phase_s;
    is_read_next     = is_read_s;
    bit_index_next   = bit_s;
    clock_phase_next = cp_s;
    wait_count_next  = wait_s;
    shift_byte_next  = shift_s;
    data_byte_next   = data_s;
    recv_byte_next   = recv_s;
    result           = '0;
    case (phase_s)
      PH_IDLE: ;
      PH_SETUP: begin
        result.ce_pin = 1'b1;
        if (!ph_end) begin
          wait_count_next = wait_s - 8'd1;
        end else begin
          phase_next       = PH_TX;
          bit_index_next   = 4'd0;
          clock_phase_next = 2'd0;
          wait_count_next  = phase_one;
        end
      end
      PH_TX: begin
        result.ce_pin   = 1'b1;
        result.io_drive = 1'b1;
        result.io_out   = tx_byte[bit_s[2:0]];
        result.sclk_pin = (cp_s == 2'd1);
        if (!ph_end) begin
          wait_count_next = wait_s - 8'd1;
        end else begin
          wait_count_next = phase_one;
          if (cp_s >= 2'd2) begin
            clock_phase_next = 2'd0;
            if (tx_last) begin
              bit_index_next = 4'd0;
              if (is_read_s) begin
                phase_next       = PH_RX;
                clock_phase_next = CP_SAMPLE;
                recv_byte_next   = 8'd0;
              end else begin
                phase_next = PH_IDLE;
              end
            end else begin
              bit_index_next = bit_s + 4'd1;
            end
          end else begin
            clock_phase_next = cp_s + 2'd1;
          end
        end
      end
      PH_RX: begin
        result.ce_pin = 1'b1;
        if (cp_s == CP_SAMPLE) begin
          recv_byte_next = recv_s | (8'(io_in) << bit_s[2:0]);
          if (bit_s >= 4'd7) begin
            phase_next      = PH_HOLD;
            wait_count_next = setup_one;
          end else begin
            clock_phase_next = 2'd0;
            wait_count_next  = phase_one;
          end
        end else begin
          result.sclk_pin = (cp_s == 2'd1);
          if (!ph_end) begin
            wait_count_next = wait_s - 8'd1;
          end else begin
            wait_count_next = phase_one;
            if (cp_s >= 2'd2) begin
              clock_phase_next = CP_SAMPLE;
              bit_index_next   = bit_s + 4'd1;
            end else begin
              clock_phase_next = cp_s + 2'd1;
            end
          end
        end
      end
      PH_HOLD: begin
        if (!ph_end) begin
          wait_count_next = wait_s - 8'd1;
        end else begin
          phase_next        = PH_IDLE;
          result.read_valid = 1'b1;
          result.read_value = from_bcd(recv_s);
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    result.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      is_read     <= 1'b0;
      bit_index   <= 4'd0;
      clock_phase <= 2'd0;
      wait_count  <= 8'd0;
      shift_byte  <= 8'd0;
      data_byte   <= 8'd0;
      recv_byte   <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      is_read     <= is_read_next;
      bit_index   <= bit_index_next;
      clock_phase <= clock_phase_next;
      wait_count  <= wait_count_next;
      shift_byte  <= shift_byte_next;
      data_byte   <= data_byte_next;
      recv_byte   <= recv_byte_next;
    end
  end

endmodule

>>> src/tw_rtc_outreg.sv
// ----------------------------------------------------------------------------
// tw_rtc_outreg
// Result register: holds one tick's result until the sink takes it and
// tells the request side when a new tick may be taken.
// ----------------------------------------------------------------------------
module tw_rtc_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tw_rtc_pkg::res_t result,
  output logic             take_ok,
  tw_rtc_res_if.source     res
);
  import tw_rtc_pkg::*;

  logic valid;
  res_t data;

  assign take_ok = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data <= result;
    end
  end

  assign res.valid      = valid;
  assign res.ce_pin     = data.ce_pin;
  assign res.sclk_pin   = data.sclk_pin;
  assign res.io_out     = data.io_out;
  assign res.io_drive   = data.io_drive;
  assign res.busy_res   = data.busy_res;
  assign res.read_valid = data.read_valid;
  assign res.read_value = data.read_value;

endmodule

>>> src/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire chip-enable/clock/data real-time-clock bus master, one bus tick
// per request.
// ----------------------------------------------------------------------------
// Every request is one bus tick and yields one result carrying the pin levels
// for that tick. One request is taken per clock cycle unless stalled; the
// sequencer step logic turns each into its result and the result register holds
// it, so a request is taken whenever that register is empty or being emptied.
// Write and read accesses run for as many requests as the programmed setup and
// clock-phase tick counts demand; commands arriving while busy_res is high are
// ignored. The user must write timing registers via cfg (index 0 setup, index 1
// phase ticks) only while no access runs; the block does not enforce it.
module three_wire_rtc_serial_master (
  input  logic        clk,
  input  logic        rst,
  tw_rtc_cmd_if.sink  cmd,
  tw_rtc_res_if.source res,
  tw_rtc_cfg_if.sink  cfg
);
  import tw_rtc_pkg::*;

  logic fire;
  logic take_ok;
  res_t result;

  assign cmd.ready = take_ok;
  assign fire      = cmd.valid && take_ok;

  tw_rtc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .func        (cmd.func),
    .reg_addr    (cmd.reg_addr),
    .write_value (cmd.write_value),
    .io_in       (cmd.io_in),
    .cfg         (cfg),
    .result      (result)
  );

  tw_rtc_outreg u_outreg (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .result  (result),
    .take_ok (take_ok),
    .res     (res)
  );

  a_read_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.read_valid |-> !res.ce_pin && !res.busy_res)
    else $error("read completion while bus still active");

  a_drive_only: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.io_out |-> res.io_drive && res.ce_pin)
    else $error("data level without drive");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.read_valid |-> res.read_value <= MAX_READ_VALUE)
    else $error("read value out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !cmd.ready)
    else $error("request taken while result stalled");

endmodule
